// ----- design/tppb_pkg.sv -----
// Package for the timestamp paced playout buffer.
// Holds result kinds, operation codes, register indexes, reset values and
// the command and status structs shared by the controller and the datapath.
package tppb_pkg;

    // Operation codes of an input beat
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_FILL_LEVEL  = 2'd0;
    localparam logic [1:0] CFG_OVF_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_JITTER_LIM  = 2'd2;

    // Configuration reset values
    localparam logic [4:0]  FILL_LEVEL_RST = 5'd4;
    localparam logic [4:0]  OVF_LIMIT_RST  = 5'd31;
    localparam logic [15:0] JITTER_RST     = 16'd200;

    // Results per tick
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Kind of a result beat
    typedef enum logic [1:0] {
        KIND_PUSH    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_DROP    = 2'd2,
        KIND_NONE    = 2'd3
    } tppb_kind_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic push;
        logic tick;
        logic calc_gap;
        logic release_head;
        logic drop_head;
        logic finish;
        logic emit_push;
    } tppb_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic drain_active;
        logic has_entries;
        logic anchor_valid;
        logic over_jitter;
        logic not_due;
        logic slot_free;
    } tppb_stat_t;

endpackage

// ----- design/timestamp_paced_playout_buffer_unit.sv -----
// Top level of the timestamp paced playout buffer.
// Joins tppb_ctrl and tppb_dpath; uses tppb_pkg for shared types.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | operation, packet_time, payload_tag
//   result  | out_valid/ out_ready | kind, out_time, out_tag, overflow_cleared,
//           |                      | last
//   config  | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// A push is accepted, then its result beat loads the output register.
// A tick runs a store read, a gap step and a compare step per head that it looks at,
// between accept and close; a compare that drops a head for jitter ends it.
// One item is in work at a time; a held result side stalls the push, compare and close steps
// until the output register frees, but not the next accept once the last beat is loaded.
// Reset is asynchronous and active low; the packet store needs no clearing.
module timestamp_paced_playout_buffer_unit
    import tppb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIME_BITS   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] packet_time,
    input  logic [31:0] payload_tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] out_time,
    output logic [31:0] out_tag,
    output logic        overflow_cleared,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    tppb_cmd_t  cmd;
    tppb_stat_t stat;

    tppb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    tppb_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .packet_time      (packet_time),
        .payload_tag      (payload_tag),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .out_time         (out_time),
        .out_tag          (out_tag),
        .overflow_cleared (overflow_cleared),
        .last             (last)
    );

    // A push beat and an empty-tick beat always close their item
    a_single_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PUSH || kind == KIND_NONE) |-> last)
        else $error("push or empty tick result without last");

    // A jitter drop ends the tick
    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DROP) |-> last)
        else $error("jitter drop not marked last");

    // Only push results carry the overflow flag
    a_ovf_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow_cleared |-> (kind == KIND_PUSH))
        else $error("overflow flag on non-push result");

    // A new item is taken only after the previous one has loaded its last beat
    a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid |-> last)
        else $error("item accepted while a partial result run is pending");

endmodule

// ----- design/tppb_ctrl.sv -----
// Controller of the playout buffer: sequences push and tick work.
// Depends on tppb_pkg for the command and status structs and operation codes.
module tppb_ctrl
    import tppb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  tppb_stat_t stat,
    output tppb_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_OUT,
        ST_READ,
        ST_GAP,
        ST_EVAL,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [RES_CNT_W-1:0]   nres_reg, nres_next;
    logic                   loop_ok;

    assign in_ready = (state_reg == ST_IDLE);
    assign loop_ok  = stat.drain_active && stat.has_entries
                      && (nres_reg < RES_CNT_W'(MAX_RESULTS));

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        nres_next  = nres_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_TICK)
                    begin
                        cmd.tick   = 1'b1;
                        nres_next  = '0;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_PUSH_OUT;
                    end
                end
            end
            ST_PUSH_OUT:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit_push = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_GAP;
            end
            ST_GAP:
            begin
                cmd.calc_gap = 1'b1;
                state_next   = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (stat.slot_free)
                begin
                    if (!loop_ok)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (!stat.anchor_valid)
                    begin
                        cmd.release_head = 1'b1;
                        nres_next        = nres_reg + 1'b1;
                        state_next       = ST_READ;
                    end
                    else if (stat.over_jitter)
                    begin
                        cmd.drop_head = 1'b1;
                        nres_next     = nres_reg + 1'b1;
                        state_next    = ST_FINISH;
                    end
                    else if (stat.not_due)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.release_head = 1'b1;
                        nres_next        = nres_reg + 1'b1;
                        state_next       = ST_READ;
                    end
                end
            end
            ST_FINISH:
            begin
                if (stat.slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nres_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nres_reg  <= nres_next;
        end
    end

endmodule

// ----- design/tppb_dpath.sv -----
// Datapath of the playout buffer: packet memory, pointers, clock and anchor,
// configuration registers, pending result and output register.
// Depends on tppb_pkg for commands, status, kinds and register indexes.
module tppb_dpath
    import tppb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIME_BITS   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [31:0] packet_time,
    input  logic [31:0] payload_tag,
    input  tppb_cmd_t   cmd,
    output tppb_stat_t  stat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] out_time,
    output logic [31:0] out_tag,
    output logic        overflow_cleared,
    output logic        last
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    // Packet store
    logic [TIME_BITS-1:0] mem_time [QUEUE_DEPTH];
    logic [31:0]          mem_tag  [QUEUE_DEPTH];

    // Control state
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 draining_reg, draining_next;
    logic                 anchor_valid_reg, anchor_valid_next;
    logic [TIME_BITS-1:0] anchor_time_reg, anchor_time_next;
    logic [TIME_BITS-1:0] last_rel_reg, last_rel_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [4:0]           fill_reg, fill_next;
    logic [4:0]           ovf_limit_reg, ovf_limit_next;
    logic [15:0]          jitter_reg, jitter_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers
    logic [TIME_BITS-1:0] rd_time_reg;
    logic [31:0]          rd_tag_reg;
    logic [TIME_BITS-1:0] gap_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic                 ovf_flag_reg;
    tppb_kind_t           pend_kind_reg;
    logic [TIME_BITS-1:0] pend_time_reg;
    logic [31:0]          pend_tag_reg;
    tppb_kind_t           out_kind_reg;
    logic [31:0]          out_time_reg;
    logic [31:0]          out_tag_reg;
    logic                 out_ovf_reg;
    logic                 out_last_reg;

    // Combinational helpers
    logic                 ovf_hit;
    logic                 slot_free;
    logic                 wr_en;
    logic [PTR_W-1:0]     wr_addr;
    logic                 take;
    logic                 move_pend;
    tppb_kind_t           take_kind;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || out_ready;
    assign ovf_hit   = (CMP_W'(count_reg) > CMP_W'(ovf_limit_reg))
                       || (count_reg >= CNT_W'(QUEUE_DEPTH));

    // Compute next control state
    always_comb
    begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        draining_next     = draining_reg;
        anchor_valid_next = anchor_valid_reg;
        anchor_time_next  = anchor_time_reg;
        last_rel_next     = last_rel_reg;
        now_next          = now_reg;
        fill_next         = fill_reg;
        ovf_limit_next    = ovf_limit_reg;
        jitter_next       = jitter_reg;
        pend_valid_next   = pend_valid_reg;
        out_valid_next    = out_valid_reg;
        wr_en             = 1'b0;
        wr_addr           = tail_reg;
        take              = 1'b0;
        move_pend         = 1'b0;
        take_kind         = KIND_RELEASE;

        // Drop the output beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Write configuration
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FILL_LEVEL: fill_next      = cfg_data[4:0];
                CFG_OVF_LIMIT:  ovf_limit_next = cfg_data[4:0];
                CFG_JITTER_LIM: jitter_next    = cfg_data;
                default:        fill_next      = fill_reg;
            endcase
        end

        // Enqueue a packet, clearing the queue on overflow
        if (cmd.push)
        begin
            wr_en = 1'b1;
            if (ovf_hit)
            begin
                wr_addr           = '0;
                head_next         = '0;
                tail_next         = ptr_inc('0);
                count_next        = CNT_W'(1);
                draining_next     = 1'b0;
                anchor_valid_next = 1'b0;
                last_rel_next     = '0;
            end
            else
            begin
                tail_next  = ptr_inc(tail_reg);
                count_next = count_reg + 1'b1;
            end
        end

        // Advance the clock and start draining once filled
        if (cmd.tick)
        begin
            now_next = now_reg + 1'b1;
            if (!draining_reg && (count_reg != '0)
                && (CMP_W'(count_reg) >= CMP_W'(fill_reg)))
            begin
                draining_next     = 1'b1;
                anchor_valid_next = 1'b0;
            end
        end

        // Release the head, setting or advancing the anchor
        if (cmd.release_head)
        begin
            anchor_time_next  = anchor_valid_reg ? anchor_time_reg + gap_reg : now_reg;
            anchor_valid_next = 1'b1;
            last_rel_next     = rd_time_reg;
            head_next         = ptr_inc(head_reg);
            count_next        = count_reg - 1'b1;
            take              = 1'b1;
            take_kind         = KIND_RELEASE;
        end

        // Drop a late head and go back to filling
        if (cmd.drop_head)
        begin
            head_next         = ptr_inc(head_reg);
            count_next        = count_reg - 1'b1;
            draining_next     = 1'b0;
            anchor_valid_next = 1'b0;
            take              = 1'b1;
            take_kind         = KIND_DROP;
        end

        // New result goes to pending; an older pending one moves out
        if (take)
        begin
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                move_pend      = 1'b1;
                out_valid_next = 1'b1;
            end
        end

        // Close a tick: stop draining when empty, flush the last result
        if (cmd.finish)
        begin
            if (draining_reg && (count_reg == '0))
            begin
                draining_next     = 1'b0;
                anchor_valid_next = 1'b0;
            end
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end

        if (cmd.emit_push)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            draining_reg     <= 1'b0;
            anchor_valid_reg <= 1'b0;
            anchor_time_reg  <= '0;
            last_rel_reg     <= '0;
            now_reg          <= '0;
            fill_reg         <= FILL_LEVEL_RST;
            ovf_limit_reg    <= OVF_LIMIT_RST;
            jitter_reg       <= JITTER_RST;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            draining_reg     <= draining_next;
            anchor_valid_reg <= anchor_valid_next;
            anchor_time_reg  <= anchor_time_next;
            last_rel_reg     <= last_rel_next;
            now_reg          <= now_next;
            fill_reg         <= fill_next;
            ovf_limit_reg    <= ovf_limit_next;
            jitter_reg       <= jitter_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Write the packet store and read the head
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_time[wr_addr] <= TIME_BITS'(packet_time);
            mem_tag[wr_addr]  <= payload_tag;
        end
        rd_time_reg <= mem_time[head_reg];
        rd_tag_reg  <= mem_tag[head_reg];
    end

    // Register gap, elapsed time and result payloads
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ovf_flag_reg <= ovf_hit;
        end
        if (cmd.calc_gap)
        begin
            gap_reg     <= rd_time_reg - last_rel_reg;
            elapsed_reg <= now_reg - anchor_time_reg;
        end
        if (take)
        begin
            pend_kind_reg <= take_kind;
            pend_time_reg <= rd_time_reg;
            pend_tag_reg  <= rd_tag_reg;
        end
        if (move_pend)
        begin
            out_kind_reg <= pend_kind_reg;
            out_time_reg <= 32'(pend_time_reg);
            out_tag_reg  <= pend_tag_reg;
            out_ovf_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_ovf_reg  <= 1'b0;
            out_last_reg <= 1'b1;
            if (pend_valid_reg)
            begin
                out_kind_reg <= pend_kind_reg;
                out_time_reg <= 32'(pend_time_reg);
                out_tag_reg  <= pend_tag_reg;
            end
            else
            begin
                out_kind_reg <= KIND_NONE;
                out_time_reg <= '0;
                out_tag_reg  <= '0;
            end
        end
        else if (cmd.emit_push)
        begin
            out_kind_reg <= KIND_PUSH;
            out_time_reg <= '0;
            out_tag_reg  <= '0;
            out_ovf_reg  <= ovf_flag_reg;
            out_last_reg <= 1'b1;
        end
    end

    // Status to the controller
    assign stat.drain_active = draining_reg;
    assign stat.has_entries  = (count_reg != '0);
    assign stat.anchor_valid = anchor_valid_reg;
    assign stat.over_jitter  = gap_reg > TIME_BITS'(jitter_reg);
    assign stat.not_due      = elapsed_reg < gap_reg;
    assign stat.slot_free    = slot_free;

    // Output ports
    assign out_valid        = out_valid_reg;
    assign kind             = out_kind_reg;
    assign out_time         = out_time_reg;
    assign out_tag          = out_tag_reg;
    assign overflow_cleared = out_ovf_reg;
    assign last             = out_last_reg;

endmodule

// ----- test/timestamp_paced_playout_buffer_unit_tb.sv -----
// Self-checking testbench for timestamp_paced_playout_buffer_unit.
// Drives pushes and ticks, predicts every result beat with its own playout model,
// and compares beats in order. Depends on tppb_pkg and the unit's RTL only.
module timestamp_paced_playout_buffer_unit_tb
    import tppb_pkg::*;
;

    localparam int QDEPTH      = 32;
    localparam int STALL_LIMIT = 1500;

    // One expected result beat
    typedef struct {
        tppb_kind_t  kind;
        logic [31:0] pkt_time;
        logic [31:0] pkt_tag;
        logic        cleared;
        logic        final_beat;
    } playout_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [31:0] packet_time;
    logic [31:0] payload_tag;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [31:0] out_time;
    logic [31:0] out_tag;
    logic        overflow_cleared;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Playout model state and register copies
    logic [31:0] q_time [QDEPTH];
    logic [31:0] q_tag [QDEPTH];
    logic [4:0]  head;
    int          fill_cnt;
    bit          draining;
    bit          anchored;
    logic [31:0] anchor_ms;
    logic [31:0] last_rel_ms;
    logic [31:0] clock_ms;
    logic [4:0]  fill_lvl;
    logic [4:0]  ovf_lim;
    logic [15:0] jit_lim;

    playout_beat_t pending_beats[$];

    // Run bookkeeping
    int mismatch_count = 0;
    int beats_checked  = 0;
    int n_push = 0, n_tick = 0, n_rel = 0, n_drop = 0, n_none = 0, n_clear = 0;
    int most_in_tick = 0;
    int quiet_cycles = 0;
    int rx_hold  = 0;
    int rx_stall = 0;
    bit tx_idling = 1'b1;
    bit rx_idling = 1'b1;

    timestamp_paced_playout_buffer_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .packet_time      (packet_time),
        .payload_tag      (payload_tag),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .out_time         (out_time),
        .out_tag          (out_tag),
        .overflow_cleared (overflow_cleared),
        .last             (last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Playout model
    // ---------------------------------------------------------------

    function automatic void model_reset();
        head        = '0;
        fill_cnt    = 0;
        draining    = 1'b0;
        anchored    = 1'b0;
        anchor_ms   = '0;
        last_rel_ms = '0;
        clock_ms    = '0;
        fill_lvl    = FILL_LEVEL_RST;
        ovf_lim     = OVF_LIMIT_RST;
        jit_lim     = JITTER_RST;
    endfunction

    // Append one expected beat behind the ones already waiting
    function automatic void expect_beat(input playout_beat_t b);
        pending_beats = {pending_beats, b};
    endfunction

    // Store a packet, clearing the queue first when it is over the limit or full
    function automatic void model_push(input logic [31:0] t, input logic [31:0] tag);
        logic [4:0] slot;
        logic       clr;
        clr = (fill_cnt > ovf_lim) || (fill_cnt >= QDEPTH);
        if (clr)
        begin
            fill_cnt    = 0;
            head        = '0;
            draining    = 1'b0;
            anchored    = 1'b0;
            last_rel_ms = '0;
            n_clear++;
        end
        slot = head + 5'(fill_cnt);
        q_time[slot] = t;
        q_tag[slot]  = tag;
        fill_cnt++;
        n_push++;
        expect_beat('{KIND_PUSH, 32'd0, 32'd0, clr, 1'b1});
    endfunction

    function automatic void pop_head();
        head = head + 5'd1;
        fill_cnt--;
    endfunction

    // Advance the clock and release every due head, or drop one over the jitter limit, up to one burst limit
    function automatic void model_tick();
        playout_beat_t burst[$];
        playout_beat_t nb;
        logic [31:0]   t;
        logic [31:0]   tg;
        logic [31:0]   gap;
        logic [31:0]   held;
        bit            stop;
        clock_ms = clock_ms + 32'd1;
        n_tick++;
        if (!draining && fill_cnt > 0 && fill_cnt >= fill_lvl)
        begin
            draining = 1'b1;
            anchored = 1'b0;
        end
        stop = 1'b0;
        while (!stop && draining && fill_cnt > 0 && burst.size() < MAX_RESULTS)
        begin
            t  = q_time[head];
            tg = q_tag[head];
            if (!anchored)
            begin
                anchored    = 1'b1;
                anchor_ms   = clock_ms;
                last_rel_ms = t;
                pop_head();
                nb    = '{KIND_RELEASE, t, tg, 1'b0, 1'b0};
                burst = {burst, nb};
            end
            else
            begin
                gap  = t - last_rel_ms;
                held = clock_ms - anchor_ms;
                if (gap > {16'd0, jit_lim})
                begin
                    pop_head();
                    draining = 1'b0;
                    anchored = 1'b0;
                    nb    = '{KIND_DROP, t, tg, 1'b0, 1'b0};
                    burst = {burst, nb};
                    n_drop++;
                    stop = 1'b1;
                end
                else if (held < gap)
                    stop = 1'b1;
                else
                begin
                    anchor_ms   = anchor_ms + gap;
                    last_rel_ms = t;
                    pop_head();
                    nb    = '{KIND_RELEASE, t, tg, 1'b0, 1'b0};
                    burst = {burst, nb};
                end
            end
        end
        if (draining && fill_cnt == 0)
        begin
            draining = 1'b0;
            anchored = 1'b0;
        end
        if (burst.size() == 0)
        begin
            nb    = '{KIND_NONE, 32'd0, 32'd0, 1'b0, 1'b0};
            burst = {burst, nb};
            n_none++;
        end
        n_rel += burst.size();
        if (burst[burst.size() - 1].kind == KIND_DROP || burst[0].kind == KIND_NONE)
            n_rel--;
        if (burst.size() > most_in_tick)
            most_in_tick = burst.size();
        burst[burst.size() - 1].final_beat = 1'b1;
        pending_beats = {pending_beats, burst};
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        playout_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_checked++;
            if (pending_beats.size() == 0)
                report_mismatch($sformatf("unexpected beat kind=%0d", kind));
            else
            begin
                want = pending_beats[0];
                pending_beats.delete(0);
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                if (out_time !== want.pkt_time)
                    report_mismatch($sformatf("out_time %h, want %h", out_time, want.pkt_time));
                if (out_tag !== want.pkt_tag)
                    report_mismatch($sformatf("out_tag %h, want %h", out_tag, want.pkt_tag));
                if (overflow_cleared !== want.cleared)
                    report_mismatch($sformatf("overflow_cleared %b, want %b",
                                              overflow_cleared, want.cleared));
                if (last !== want.final_beat)
                    report_mismatch($sformatf("last %b, want %b", last, want.final_beat));
            end
        end
    end

    // Abort when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timestamp_paced_playout_buffer_unit_tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: long hold-off first, then random stall bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready = 1'b0;
                rx_hold   = rx_hold - 1;
            end
            else if (rx_stall > 0)
            begin
                out_ready = 1'b0;
                rx_stall  = rx_stall - 1;
            end
            else
            begin
                out_ready = 1'b1;
                if (rx_idling && $urandom_range(0, 7) == 0)
                    rx_stall = $urandom_range(1, 14);
            end
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Offer one input beat, hold it until accepted, then predict its results
    task automatic send_item(input logic op, input logic [31:0] t, input logic [31:0] tag);
        @(negedge clk);
        in_valid    = 1'b1;
        operation   = op;
        packet_time = t;
        payload_tag = tag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op == OP_PUSH)
            model_push(t, tag);
        else
            model_tick();
        if (tx_idling && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 13))
                @(negedge clk);
        end
    endtask

    // Drop valid and wait until every expected beat has come back
    task automatic settle_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FILL_LEVEL: fill_lvl = data[4:0];
            CFG_OVF_LIMIT:  ovf_lim  = data[4:0];
            CFG_JITTER_LIM: jit_lim  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Write all three registers while idle; junk in the unused upper bits
    task automatic write_config(input logic [4:0] fill, input logic [4:0] ovf,
                                input logic [15:0] jit);
        logic [15:0] junk;
        settle_idle();
        junk = 16'($urandom);
        write_register(CFG_FILL_LEVEL, {junk[15:5], fill});
        junk = 16'($urandom);
        write_register(CFG_OVF_LIMIT, {junk[15:5], ovf});
        write_register(CFG_JITTER_LIM, jit);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Tick on empty, then drain four packets across the timestamp wrap
    task automatic test_wrap_release();
        send_item(OP_TICK, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_PUSH, 32'hFFFF_FFFE, 32'h0000_0000);
        send_item(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_PUSH, 32'h0000_0000, 32'h5A5A_5A5A);
        send_item(OP_PUSH, 32'h0000_0002, 32'hA5A5_A5A5);
        repeat (5)
            send_item(OP_TICK, 32'h0, 32'hFFFF_FFFF);
    endtask

    // Gap equal to the limit is released, one above it is dropped
    task automatic test_jitter_drop();
        write_config(5'd2, 5'd31, 16'd3);
        send_item(OP_PUSH, 32'd10, 32'h1111_0001);
        send_item(OP_PUSH, 32'd13, 32'h1111_0002);
        send_item(OP_PUSH, 32'd17, 32'h1111_0003);
        repeat (4)
            send_item(OP_TICK, 32'h0, 32'h0);
    endtask

    // Push over the overflow limit clears; zero fill level drains at once
    task automatic test_overflow_clear();
        write_config(5'd0, 5'd1, 16'd200);
        send_item(OP_TICK, 32'h0, 32'h0);
        send_item(OP_PUSH, 32'h8000_0000, 32'h2222_0001);
        send_item(OP_PUSH, 32'h8000_0001, 32'h2222_0002);
        send_item(OP_PUSH, 32'h8000_0002, 32'h2222_0003);
        send_item(OP_TICK, 32'h0, 32'h0);
    endtask

    // Fill the queue behind a held result side, release a full burst,
    // then push past the depth so the full queue is cleared
    task automatic test_full_queue();
        logic [31:0] base;
        write_config(5'd31, 5'd31, 16'hFFFF);
        tx_idling = 1'b0;
        base = $urandom;
        @(posedge clk);
        rx_hold = 200;
        repeat (QDEPTH)
            send_item(OP_PUSH, base, $urandom);
        send_item(OP_TICK, $urandom, $urandom);
        for (int i = 0; i <= QDEPTH; i++)
            send_item(OP_PUSH, base + i, $urandom);
        send_item(OP_TICK, $urandom, $urandom);
        tx_idling = 1'b1;
    endtask

    // Mostly paced streams with small gaps; some over-limit gaps and wild times
    task automatic run_random_phase(input int items, input int push_pct);
        logic [31:0] stream_ms;
        logic [31:0] step;
        int          sel;
        stream_ms = $urandom;
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 99) < push_pct)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 14)
                    step = $urandom_range(0, (jit_lim < 4) ? jit_lim : 4);
                else if (sel < 17)
                    step = {16'd0, jit_lim} + 32'd1 + $urandom_range(0, 40);
                else
                    step = $urandom;
                stream_ms = stream_ms + step;
                send_item(OP_PUSH, stream_ms, $urandom);
            end
            else
                send_item(OP_TICK, $urandom, $urandom);
        end
    endtask

    task automatic test_random_traffic();
        write_config(FILL_LEVEL_RST, OVF_LIMIT_RST, JITTER_RST);
        run_random_phase(30, 55);

        tx_idling = 1'b0;
        write_config(5'd0, 5'd1, 16'd0);
        run_random_phase(25, 50);

        tx_idling = 1'b1;
        rx_idling = 1'b0;
        write_config(5'd31, 5'd31, 16'hFFFF);
        run_random_phase(25, 75);

        rx_idling = 1'b1;
        write_config(5'($urandom_range(1, 8)), 5'($urandom_range(2, 24)),
                     16'($urandom_range(0, 20)));
        run_random_phase(25, 55);

        // closing stretch runs at full rate on both sides
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        write_config(5'($urandom_range(0, 31)), 5'($urandom_range(1, 31)),
                     16'($urandom_range(0, 300)));
        run_random_phase(25, 55);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = OP_PUSH;
        packet_time = '0;
        payload_tag = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_FILL_LEVEL;
        cfg_data    = '0;
        model_reset();
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;

        test_wrap_release();
        test_jitter_drop();
        test_overflow_clear();
        test_full_queue();
        test_random_traffic();

        settle_idle();
        repeat (20)
            @(posedge clk);

        $display("Run: %0d pushes, %0d ticks, %0d beats checked, %0d overflow clears",
                 n_push, n_tick, beats_checked, n_clear);
        $display("Drain: %0d released, %0d jitter drops, %0d idle ticks, largest burst %0d",
                 n_rel, n_drop, n_none, most_in_tick);
        if (mismatch_count == 0)
            $display("timestamp_paced_playout_buffer_unit_tb: clean");
        else
            $display("timestamp_paced_playout_buffer_unit_tb: errors");
        $finish;
    end

endmodule
